[hw/rtl/mse_pkg.sv]
// Shared constants and inter-cell types of the merge sort engine.
package mse_pkg;

	localparam int unsigned VAL_W     = 32;
	localparam int unsigned DEPTH_DEF = 64;

	// Value travelling rightward from a cell to its neighbor while the set loads.
	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] value;
	} carry_t;

	// Contents of one cell, read by its left neighbor while the set drains.
	typedef struct packed {
		logic                    full;
		logic signed [VAL_W-1:0] value;
	} slot_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic shift;
	} cell_ctrl_t;

endpackage

[hw/rtl/mse_in_if.sv]
// Input channel of the merge sort engine: one element and its end-of-set mark per beat.
interface mse_in_if;
	logic                           valid;
	logic                           ready;
	logic signed [mse_pkg::VAL_W-1:0] value;
	logic                           last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

[hw/rtl/mse_out_if.sv]
// Output channel of the merge sort engine: one sorted element per beat.
interface mse_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [mse_pkg::VAL_W-1:0] value_res;
	logic                           last_res;
	logic                           overflowed;

	modport source (output valid, output value_res, output last_res, output overflowed,
		input ready);
	modport sink   (input valid, input value_res, input last_res, input overflowed,
		output ready);
endinterface

[hw/rtl/mse_cell.sv]
// One sorting cell: keeps the smaller of its key and an arriving value, passes the larger on.
module mse_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  mse_pkg::cell_ctrl_t ctrl,
	input  mse_pkg::carry_t     carry_in,
	output mse_pkg::carry_t     carry_out,
	input  mse_pkg::slot_t      slot_in,
	output mse_pkg::slot_t      slot_out
);
	import mse_pkg::*;

	logic                    full_q;
	logic signed [VAL_W-1:0] key_q;
	logic                    pass_valid_q;
	logic signed [VAL_W-1:0] pass_value_q;
	logic                    keep_new;
	logic                    pass_valid;
	logic signed [VAL_W-1:0] pass_value;

	// An arriving value is kept if the cell is empty or the value is smaller than the key.
	always_comb begin
		keep_new   = carry_in.valid && (!full_q || (carry_in.value < key_q));
		pass_valid = carry_in.valid && full_q;
		pass_value = keep_new ? key_q : carry_in.value;
	end

	// Occupancy and the outgoing carry flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q       <= 1'b0;
			pass_valid_q <= 1'b0;
		end else begin
			pass_valid_q <= !ctrl.shift && pass_valid;
			if (ctrl.shift) begin
				full_q <= slot_in.full;
			end else if (carry_in.valid) begin
				full_q <= 1'b1;
			end
		end
	end

	// Key and the outgoing carry value.
	always_ff @(posedge clk) begin
		pass_value_q <= pass_value;
		if (ctrl.shift) begin
			key_q <= slot_in.value;
		end else if (keep_new) begin
			key_q <= carry_in.value;
		end
	end

	assign carry_out = '{valid: pass_valid_q, value: pass_value_q};
	assign slot_out  = '{full: full_q, value: key_q};

endmodule

[hw/rtl/merge_sort_engine.sv]
// Top level of the merge sort engine: a row of sorting cells and its sequencer.
//
// Usage: elements arrive on in_ch, one signed 32-bit value per beat; the beat with
// last set closes the set. Up to DEPTH elements are kept; later ones in the same set
// are dropped and every result of that set carries overflowed. The sorted set leaves
// on out_ch in ascending order, one beat per element, with last_res on the final one.
// While loading, each value enters the first cell and ripples right, one cell per
// cycle, each cell keeping the smaller value. After the last beat the chain settles
// for the worst ripple length, counted down by a timer. Draining then moves the first
// cell's value into the output register, one result per cycle while out_ch.ready is
// high; the cells shift left one place per result.
// in_ch.ready is high only while loading; the next set may start loading while the
// final result still waits in the output register.
// When the receiver stalls, the output register holds its beat and the chain waits.
// Reset empties every cell, clears the count and the overflow mark, and leaves the
// block ready for a new set; key values are not cleared.
module merge_sort_engine #(
	parameter int unsigned DEPTH = mse_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mse_in_if.sink    in_ch,
	mse_out_if.source out_ch
);
	import mse_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETTLE,
		ST_DRAIN
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           timer_q;
	logic                    ovf_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_last_q;
	logic                    out_ovf_q;

	carry_t     carry [DEPTH+1];
	slot_t      slot  [DEPTH+1];
	cell_ctrl_t ctrl;
	logic       in_acc;
	logic       store;
	logic       out_free;
	logic       pop;

	// Handshake decode.
	always_comb begin
		in_acc     = in_ch.valid && in_ch.ready;
		store      = in_acc && (count_q < CW'(DEPTH));
		out_free   = !out_valid_q || out_ch.ready;
		pop        = (state_q == ST_DRAIN) && out_free && (count_q != '0);
		ctrl.shift = pop;
	end

	assign in_ch.ready       = (state_q == ST_LOAD);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.value_res  = out_value_q;
	assign out_ch.last_res   = out_last_q;
	assign out_ch.overflowed = out_ovf_q;

	// Ends of the chain: new values enter on the left, empty slots on the right.
	assign carry[0]   = '{valid: store, value: in_ch.value};
	assign slot[DEPTH] = '{full: 1'b0, value: '0};

	// Row of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mse_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.carry_out (carry[i+1]),
			.slot_in   (slot[i+1]),
			.slot_out  (slot[i])
		);
	end

	// Sequencer: load, let the ripples settle, then drain through the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			timer_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && !pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (store) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_ch.last) begin
							state_q <= ST_SETTLE;
							timer_q <= CW'(DEPTH);
						end
					end
				end
				ST_SETTLE: begin
					timer_q <= timer_q - CW'(1);
					if (timer_q == CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pop) begin
						out_valid_q <= 1'b1;
						out_value_q <= slot[0].value;
						out_last_q  <= (count_q == CW'(1));
						out_ovf_q   <= ovf_q;
						count_q     <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q <= ST_LOAD;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// No value may ever ripple out past the last cell.
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!carry[DEPTH].valid)
		else $error("value rippled out of the cell chain");

	// While elements are still owed during draining, the first cell is full.
	a_head_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) && (count_q != '0) |-> slot[0].full)
		else $error("drain found the first cell empty");

	// No carry leaves the first cell while draining.
	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !carry[1].valid)
		else $error("carry still moving while draining");

	// The final beat of a set is emitted exactly when the count runs out.
	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_last_q == (count_q == '0)))
		else $error("last_res out of step with the element count");

endmodule
